/* rtl/assert_macros.svh */
// Assertion macros for the RTL files; included by rgb_hue_rotate.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, held off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* rtl/rhr_pkg.sv */
// Package for rgb_hue_rotate: widths, coefficient types and the per-degree
// coefficient table built at elaboration. No dependencies.
package rhr_pkg;

    localparam int COEF_FRAC_BITS = 14;
    localparam int COEF_W         = COEF_FRAC_BITS + 2;   // |coef| <= 1.0
    localparam int ACC_W          = COEF_FRAC_BITS + 11;  // 3 x (coef * 255)
    localparam int PIX_W          = 8;
    localparam int HUE_W          = 9;
    localparam int IDX_W          = 8;                    // 0..180

    localparam int FULL_TURN = 360;
    localparam int HALF_TURN = 180;
    localparam int QUARTER   = 90;

    localparam int      ROUND_SH = 30 - COEF_FRAC_BITS;
    localparam longint  Q30_ONE  = 64'sd1 <<< 30;
    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam longint  K_Q30    = 64'sd619925131;

    localparam logic [63:0] SERIES_DIV [0:6] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210};

    typedef logic signed [COEF_W-1:0] coef_t;

    typedef struct packed {
        coef_t diag;
        coef_t plus;
        coef_t minus;
    } coef_set_t;

    typedef coef_set_t [HALF_TURN:0] coef_table_t;

    // Q30 sine of a whole degree in 0..90, Taylor series to x^15.
    function automatic longint sine_q30(input int unsigned a);
        logic [63:0] x;
        logic [63:0] term;
        longint      sum;
        x    = (64'(a) * PI_Q30 + 64'd90) / 64'd180;
        term = x;
        sum  = longint'(x);
        for (int i = 0; i < 7; i++)
        begin
            term = (((term * x) >> 30) * x) >> 30;
            term = term / SERIES_DIV[i];
            if (!i[0])
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > Q30_ONE)
            sum = Q30_ONE;
        return sum;
    endfunction

    // Q30 to COEF_FRAC_BITS, nearest, ties away from zero.
    function automatic coef_t round_coef(input longint v);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'sd1 <<< (ROUND_SH - 1))) >>> ROUND_SH;
        return COEF_W'((v < 0) ? -mag : mag);
    endfunction

    // Coefficients for 0..180 degrees; 181..359 mirror with plus/minus swapped.
    function automatic coef_table_t build_coef_table();
        coef_table_t tbl;
        longint s;
        longint c;
        longint third;
        longint ks;
        for (int e = 0; e <= HALF_TURN; e++)
        begin
            if (e <= QUARTER)
            begin
                s = sine_q30(e);
                c = sine_q30(QUARTER - e);
            end
            else
            begin
                s = sine_q30(HALF_TURN - e);
                c = -sine_q30(e - QUARTER);
            end
            third = (Q30_ONE - c) / 3;
            ks    = (s * K_Q30) >>> 30;
            tbl[e].diag  = round_coef(c + third);
            tbl[e].plus  = round_coef(third + ks);
            tbl[e].minus = round_coef(third - ks);
        end
        return tbl;
    endfunction

    localparam coef_table_t COEF_TABLE = build_coef_table();

endpackage

/* rtl/rhr_if.sv */
// Valid/ready channel interfaces for the pixel input and result streams.
// Depends on rhr_pkg for the channel width.
interface rhr_in_if import rhr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;

    modport source (output valid, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface rhr_out_if import rhr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;

    modport source (output valid, red_out, green_out, blue_out, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

/* rtl/rgb_hue_rotate.sv */
// rgb_hue_rotate top level: hue rotation of an RGB pixel stream.
// Depends on rhr_pkg, rhr_in_if/rhr_out_if, rhr_channel, assert_macros.svh.
//
//   Channel  | Dir | Handshake      | Payload
//   ---------+-----+----------------+----------------------------------
//   pixel    | in  | valid / ready  | red_in, green_in, blue_in (8b)
//   result   | out | valid / ready  | red_out, green_out, blue_out (8b)
//   cfg      | in  | cfg_we         | cfg_wdata = hue_degrees (9b)
//
// One item per cycle sustained while the result sink is ready; an accepted item
// passes the input register, then the result register, before result valid rises.
// The matrix comes from a 181-entry constant table on a hue_degrees write
// and sits in coefficient registers.
// Reset (rst_n, async, active low) empties both stages, loads zero degrees.
// A stalled result holds its register; input is ready while the input register is empty or the stage ahead can move.
`include "assert_macros.svh"

module rgb_hue_rotate import rhr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    rhr_in_if.sink           pixel,
    rhr_out_if.source        result,
    input  logic             cfg_we,
    input  logic [HUE_W-1:0] cfg_wdata
);
    // ---------------- coefficient registers ----------------
    coef_set_t        coef_reg;
    coef_set_t        coef_next;
    coef_set_t        coef_entry;
    logic [HUE_W-1:0] hue_wrapped;
    logic [HUE_W-1:0] hue_fold;
    logic             hue_mirror;

    // Values 360..511 wrap once; beyond 180 the angle folds to 360-d, which
    // keeps cos and negates sin, so plus and minus trade places.
    always_comb
    begin
        if (cfg_wdata >= HUE_W'(FULL_TURN))
            hue_wrapped = cfg_wdata - HUE_W'(FULL_TURN);
        else
            hue_wrapped = cfg_wdata;
        hue_mirror = (hue_wrapped > HUE_W'(HALF_TURN));
        hue_fold   = hue_mirror ? (HUE_W'(FULL_TURN) - hue_wrapped) : hue_wrapped;
        coef_entry = COEF_TABLE[hue_fold[IDX_W-1:0]];
        coef_next.diag  = coef_entry.diag;
        coef_next.plus  = hue_mirror ? coef_entry.minus : coef_entry.plus;
        coef_next.minus = hue_mirror ? coef_entry.plus  : coef_entry.minus;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            coef_reg <= COEF_TABLE[0];
        else if (cfg_we)
            coef_reg <= coef_next;
    end

    // ---------------- pipeline control ----------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic out_advance;
    logic s1_advance;

    // Result register loads whenever it is empty or being drained.
    assign out_advance = !out_valid_reg || result.ready;
    assign s1_advance  = !s1_valid_reg || out_advance;
    assign pixel.ready = s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_advance)
                s1_valid_reg <= pixel.valid;
            if (out_advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // ---------------- input register ----------------
    logic [PIX_W-1:0] r_reg;
    logic [PIX_W-1:0] g_reg;
    logic [PIX_W-1:0] b_reg;

    always_ff @(posedge clk)
    begin
        if (pixel.valid && s1_advance)
        begin
            r_reg <= pixel.red_in;
            g_reg <= pixel.green_in;
            b_reg <= pixel.blue_in;
        end
    end

    // ---------------- matrix rows ----------------
    // red: diag, minus, plus; green: plus, diag, minus; blue: minus, plus, diag
    logic [PIX_W-1:0] red_next;
    logic [PIX_W-1:0] green_next;
    logic [PIX_W-1:0] blue_next;

    rhr_channel u_red
    (
        .m0 (coef_reg.diag),
        .m1 (coef_reg.minus),
        .m2 (coef_reg.plus),
        .r  (r_reg),
        .g  (g_reg),
        .b  (b_reg),
        .y  (red_next)
    );

    rhr_channel u_green
    (
        .m0 (coef_reg.plus),
        .m1 (coef_reg.diag),
        .m2 (coef_reg.minus),
        .r  (r_reg),
        .g  (g_reg),
        .b  (b_reg),
        .y  (green_next)
    );

    rhr_channel u_blue
    (
        .m0 (coef_reg.minus),
        .m1 (coef_reg.plus),
        .m2 (coef_reg.diag),
        .r  (r_reg),
        .g  (g_reg),
        .b  (b_reg),
        .y  (blue_next)
    );

    // ---------------- result register ----------------
    logic [PIX_W-1:0] red_reg;
    logic [PIX_W-1:0] green_reg;
    logic [PIX_W-1:0] blue_reg;

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && out_advance)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.red_out   = red_reg;
    assign result.green_out = green_reg;
    assign result.blue_out  = blue_reg;

    // ---------------- checks ----------------
    // Both stages full and the sink stalled: no room for another item.
    `ASSERT_IMPLIES(a_full_backpressure, clk, rst_n,
        out_valid_reg && !result.ready && s1_valid_reg, !pixel.ready)
    // An accepted item lands in the input register.
    `ASSERT_NEXT(a_accept_fills_s1, clk, rst_n,
        pixel.valid && pixel.ready, s1_valid_reg)
    // A held item moves into the result register when it can.
    `ASSERT_NEXT(a_s1_moves_out, clk, rst_n,
        s1_valid_reg && out_advance, out_valid_reg)

endmodule

/* rtl/rhr_channel.sv */
// One output channel: matrix row dotted with the pixel, truncate, saturate.
// Depends on rhr_pkg.
module rhr_channel import rhr_pkg::*;
(
    input  coef_t            m0,
    input  coef_t            m1,
    input  coef_t            m2,
    input  logic [PIX_W-1:0] r,
    input  logic [PIX_W-1:0] g,
    input  logic [PIX_W-1:0] b,
    output logic [PIX_W-1:0] y
);
    logic signed [ACC_W-1:0] p0;
    logic signed [ACC_W-1:0] p1;
    logic signed [ACC_W-1:0] p2;
    logic signed [ACC_W-1:0] acc;

    always_comb
    begin
        p0  = ACC_W'(m0) * $signed({{(ACC_W-PIX_W){1'b0}}, r});
        p1  = ACC_W'(m1) * $signed({{(ACC_W-PIX_W){1'b0}}, g});
        p2  = ACC_W'(m2) * $signed({{(ACC_W-PIX_W){1'b0}}, b});
        acc = p0 + p1 + p2;
        if (acc[ACC_W-1])
            y = '0;
        else if (|acc[ACC_W-2:COEF_FRAC_BITS+PIX_W])
            y = '1;
        else
            y = acc[COEF_FRAC_BITS+PIX_W-1:COEF_FRAC_BITS];
    end
endmodule
